### src/ipv4_vxlan_frame_filter_assert.svh
// ----------------------------------------------------------------------------
// ipv4_vxlan_frame_filter assertion macros
// shared property wrappers for the frame filter checks
// ----------------------------------------------------------------------------
`ifndef IPV4_VXLAN_FRAME_FILTER_ASSERT_SVH
`define IPV4_VXLAN_FRAME_FILTER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define VFF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame filter check failed");

// next-cycle implication, disabled while in reset
`define VFF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame filter sequencing check failed");

`endif

### src/vff_pkg.sv
// ----------------------------------------------------------------------------
// vff_pkg
// constants and types for the ipv4 / vxlan frame filter
// ----------------------------------------------------------------------------
`default_nettype none

package vff_pkg;

  // verdict reasons, zero means the frame passes
  typedef enum logic [3:0] {
    VERDICT_OK        = 4'd0,
    VERDICT_ETHERTYPE = 4'd1,
    VERDICT_VERSION   = 4'd2,
    VERDICT_ADDRESS   = 4'd3,
    VERDICT_FRAGMENT  = 4'd4,
    VERDICT_PROTOCOL  = 4'd5,
    VERDICT_SHORT     = 4'd6,
    VERDICT_DEPTH     = 4'd7,
    VERDICT_BAD_IHL   = 4'd8
  } verdict_t;

  // configuration register indexes
  localparam logic CFG_PHYSICAL_PREFIX = 1'b0;
  localparam logic CFG_VIRTUAL_PREFIX  = 1'b1;

  localparam logic [23:0] PHYSICAL_PREFIX_RESET = 24'hC0A800;
  localparam logic [23:0] VIRTUAL_PREFIX_RESET  = 24'h010000;

  localparam int unsigned MAX_NESTING_DEFAULT = 4;

  // byte offsets within one layer
  localparam logic [6:0] OFF_TYPE_HI  = 7'd12;
  localparam logic [6:0] OFF_TYPE_LO  = 7'd13;
  localparam logic [6:0] OFF_VER_IHL  = 7'd14;
  localparam logic [6:0] OFF_FRAG_HI  = 7'd20;
  localparam logic [6:0] OFF_FRAG_LO  = 7'd21;
  localparam logic [6:0] OFF_PROTO    = 7'd23;
  localparam logic [6:0] OFF_DST0     = 7'd30;
  localparam logic [6:0] OFF_DST1     = 7'd31;
  localparam logic [6:0] OFF_DST2     = 7'd32;
  localparam logic [6:0] OFF_ETH_LEN  = 7'd14;
  localparam logic [6:0] OFF_MAX      = 7'd127;
  localparam logic [6:0] TUNNEL_LAST  = 7'd15;  // udp + vxlan headers, minus one

  localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
  localparam logic [7:0]  ETHERTYPE_LO = 8'h00;
  localparam logic [3:0]  IP_VERSION4  = 4'd4;
  localparam logic [3:0]  IHL_MIN      = 4'd5;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] VXLAN_PORT   = 16'd4789;

endpackage

`default_nettype wire

### src/ipv4_vxlan_frame_filter.sv
// ----------------------------------------------------------------------------
// ipv4_vxlan_frame_filter
// byte-serial ipv4 header filter with optional vxlan descent, one verdict
// per frame on its last byte
// ----------------------------------------------------------------------------
//
//  channel  | dir | content
//  ---------+-----+--------------------------------------------------------
//  s_axis   | in  | one frame byte per transfer, tlast ends frame
//  m_axis   | out | one verdict per frame
//  cfg      | in  | prefix register writes, no handshake
//
//  one byte is taken every cycle unless a last byte waits on a stalled verdict;
//  each byte passes an input register and one pass of header logic, the verdict
//  register is loaded from the last byte and lets next-frame bytes flow while held
//  a stalled verdict stops input only once a further last byte is waiting
//  reset is synchronous and clears control state and the prefix registers
//
`default_nettype none

module ipv4_vxlan_frame_filter #(
  parameter int unsigned MAX_NESTING = vff_pkg::MAX_NESTING_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] frame_byte
  input  wire logic        s_axis_tlast,   // last_byte
  input  wire logic        s_axis_tuser,   // [0] deep_mode
  // verdicts
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [0] accepted, [4:1] verdict_code,
                                           // [7:5] nesting_level
  output logic             m_axis_tuser,   // [0] is_udp
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data
);

  // prefix registers
  logic [23:0] physical_net_prefix;
  logic [23:0] virtual_net_prefix;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        s1_deep;
  logic        s1_move;

  // parser state
  logic [6:0]        layer_offset, layer_offset_next;
  logic [3:0]        header_length_words, header_length_words_next;
  logic [7:0]        field_high_byte, field_high_byte_next;
  logic [1:0]        address_match_flags, address_match_flags_next;
  logic              protocol_is_udp, protocol_is_udp_next;
  logic              verdict_latched, verdict_latched_next;
  vff_pkg::verdict_t verdict_reason, verdict_reason_next;
  logic [2:0]        depth_count, depth_count_next;
  logic              deep_latched, deep_latched_next;
  logic              first_of_frame;
  vff_pkg::verdict_t out_code_next;

  // result register
  logic              out_valid;
  logic              out_accepted;
  vff_pkg::verdict_t out_code;
  logic [2:0]        out_depth;
  logic              out_udp;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      physical_net_prefix <= vff_pkg::PHYSICAL_PREFIX_RESET;
      virtual_net_prefix  <= vff_pkg::VIRTUAL_PREFIX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vff_pkg::CFG_PHYSICAL_PREFIX: physical_net_prefix <= cfg_data;
        vff_pkg::CFG_VIRTUAL_PREFIX:  virtual_net_prefix  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: a non-last byte never waits on the verdict side
  assign s1_move       = s1_valid && (!s1_last || !out_valid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_byte <= s_axis_tdata;
      s1_last <= s_axis_tlast;
      s1_deep <= s_axis_tuser;
    end
  end

  // header logic for the byte in the input register
  always_comb begin
    logic [6:0]  off;
    logic [6:0]  l4;
    logic [7:0]  pref_p;
    logic [7:0]  pref_v;
    logic        next_layer;
    logic [15:0] port;

    // a new frame starts from a clean layer
    off        = first_of_frame ? '0 : layer_offset;
    header_length_words_next = first_of_frame ? '0 : header_length_words;
    field_high_byte_next     = first_of_frame ? '0 : field_high_byte;
    address_match_flags_next = first_of_frame ? 2'b11 : address_match_flags;
    protocol_is_udp_next     = first_of_frame ? 1'b0 : protocol_is_udp;
    verdict_latched_next     = first_of_frame ? 1'b0 : verdict_latched;
    verdict_reason_next      = first_of_frame ? vff_pkg::VERDICT_OK : verdict_reason;
    depth_count_next         = first_of_frame ? '0 : depth_count;
    deep_latched_next        = first_of_frame ? s1_deep : deep_latched;

    l4         = vff_pkg::OFF_ETH_LEN + {1'b0, header_length_words_next, 2'b00};
    next_layer = 1'b0;
    port       = {field_high_byte_next, s1_byte};

    // destination prefix byte for this offset
    pref_p = physical_net_prefix[7:0];
    pref_v = virtual_net_prefix[7:0];
    if (off == vff_pkg::OFF_DST0) begin
      pref_p = physical_net_prefix[23:16];
      pref_v = virtual_net_prefix[23:16];
    end else if (off == vff_pkg::OFF_DST1) begin
      pref_p = physical_net_prefix[15:8];
      pref_v = virtual_net_prefix[15:8];
    end

    if (!verdict_latched_next) begin
      priority if (off == vff_pkg::OFF_TYPE_HI) begin
        if (s1_byte != vff_pkg::ETHERTYPE_HI) begin
          verdict_latched_next = 1'b1;
          verdict_reason_next  = vff_pkg::VERDICT_ETHERTYPE;
        end
      end else if (off == vff_pkg::OFF_TYPE_LO) begin
        if (s1_byte != vff_pkg::ETHERTYPE_LO) begin
          verdict_latched_next = 1'b1;
          verdict_reason_next  = vff_pkg::VERDICT_ETHERTYPE;
        end
      end else if (off == vff_pkg::OFF_VER_IHL) begin
        header_length_words_next = s1_byte[3:0];
        if (s1_byte[7:4] != vff_pkg::IP_VERSION4) begin
          verdict_latched_next = 1'b1;
          verdict_reason_next  = vff_pkg::VERDICT_VERSION;
        end else if (s1_byte[3:0] < vff_pkg::IHL_MIN) begin
          verdict_latched_next = 1'b1;
          verdict_reason_next  = vff_pkg::VERDICT_BAD_IHL;
        end
      end else if (off == vff_pkg::OFF_FRAG_HI) begin
        field_high_byte_next = s1_byte;
      end else if (off == vff_pkg::OFF_FRAG_LO) begin
        // fragment failure held until the address is known
        if ({field_high_byte_next[4:0], s1_byte} != 13'd0 &&
            verdict_reason_next == vff_pkg::VERDICT_OK) begin
          verdict_reason_next = vff_pkg::VERDICT_FRAGMENT;
        end
      end else if (off == vff_pkg::OFF_PROTO) begin
        protocol_is_udp_next = (s1_byte == vff_pkg::PROTO_UDP);
        if (s1_byte != vff_pkg::PROTO_UDP && s1_byte != vff_pkg::PROTO_TCP &&
            verdict_reason_next == vff_pkg::VERDICT_OK) begin
          verdict_reason_next = vff_pkg::VERDICT_PROTOCOL;
        end
      end else if (off >= vff_pkg::OFF_DST0 && off <= vff_pkg::OFF_DST2) begin
        if (pref_p != s1_byte) address_match_flags_next[0] = 1'b0;
        if (pref_v != s1_byte) address_match_flags_next[1] = 1'b0;
        // last address byte settles address, fragment and protocol
        if (off == vff_pkg::OFF_DST2) begin
          if (address_match_flags_next == 2'b00) begin
            verdict_latched_next = 1'b1;
            verdict_reason_next  = vff_pkg::VERDICT_ADDRESS;
          end else if (verdict_reason_next != vff_pkg::VERDICT_OK) begin
            verdict_latched_next = 1'b1;
          end else if (!deep_latched_next || !protocol_is_udp_next) begin
            verdict_latched_next = 1'b1;
          end
        end
      end else if (off > vff_pkg::OFF_DST2) begin
        // udp destination port, then the tunnel skip
        if (off == l4 + 7'd2) begin
          field_high_byte_next = s1_byte;
        end else if (off == l4 + 7'd3) begin
          if (port != vff_pkg::VXLAN_PORT) begin
            verdict_latched_next = 1'b1;
          end else if (depth_count_next >= 3'(MAX_NESTING)) begin
            verdict_latched_next = 1'b1;
            verdict_reason_next  = vff_pkg::VERDICT_DEPTH;
          end else begin
            depth_count_next = depth_count_next + 3'd1;
          end
        end else if (off == l4 + vff_pkg::TUNNEL_LAST) begin
          next_layer = 1'b1;
        end
      end

      // advance the offset or open the inner layer
      if (!verdict_latched_next) begin
        if (next_layer) begin
          off                      = '0;
          header_length_words_next = '0;
          field_high_byte_next     = '0;
          address_match_flags_next = 2'b11;
          protocol_is_udp_next     = 1'b0;
          verdict_reason_next      = vff_pkg::VERDICT_OK;
        end else if (off < vff_pkg::OFF_MAX) begin
          off = off + 7'd1;
        end
      end
    end

    layer_offset_next = off;
    out_code_next = verdict_latched_next ? verdict_reason_next : vff_pkg::VERDICT_SHORT;
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_offset        <= '0;
      header_length_words <= '0;
      field_high_byte     <= '0;
      address_match_flags <= 2'b11;
      protocol_is_udp     <= 1'b0;
      verdict_latched     <= 1'b0;
      verdict_reason      <= vff_pkg::VERDICT_OK;
      depth_count         <= '0;
      deep_latched        <= 1'b0;
      first_of_frame      <= 1'b1;
    end else if (s1_move) begin
      layer_offset        <= layer_offset_next;
      header_length_words <= header_length_words_next;
      field_high_byte     <= field_high_byte_next;
      address_match_flags <= address_match_flags_next;
      protocol_is_udp     <= protocol_is_udp_next;
      verdict_latched     <= verdict_latched_next;
      verdict_reason      <= verdict_reason_next;
      depth_count         <= depth_count_next;
      deep_latched        <= deep_latched_next;
      first_of_frame      <= s1_last;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move && s1_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_last) begin
      out_accepted <= (out_code_next == vff_pkg::VERDICT_OK);
      out_code     <= out_code_next;
      out_depth    <= depth_count_next;
      out_udp      <= protocol_is_udp_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_depth, out_code, out_accepted};
  assign m_axis_tuser  = out_udp;

  // checks
`include "ipv4_vxlan_frame_filter_assert.svh"

  `VFF_ASSERT_IMPLY(a_accept_matches_code, clk, rst, m_axis_tvalid, (m_axis_tdata[0] == (m_axis_tdata[4:1] == vff_pkg::VERDICT_OK)))
  `VFF_ASSERT_IMPLY(a_depth_bounded, clk, rst, m_axis_tvalid, (m_axis_tdata[7:5] <= 3'(MAX_NESTING)))
  `VFF_ASSERT_NEXT(a_last_yields_verdict, clk, rst, (s1_move && s1_last), m_axis_tvalid)

endmodule

`default_nettype wire
